### rtl/core/timestamped_input_history_ring_unit_assert.svh
// assertion macros for the timestamped input history ring unit
// no dependencies; included by the file that carries concurrent checks
`ifndef TIMESTAMPED_INPUT_HISTORY_RING_UNIT_ASSERT_SVH
`define TIMESTAMPED_INPUT_HISTORY_RING_UNIT_ASSERT_SVH

`ifndef SYNTH
`define TIHR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tihr check failed: same cycle implication");
`define TIHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tihr check failed: next cycle implication");
`else
`define TIHR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TIHR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/tihr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the timestamped input history ring unit
// no dependencies
package tihr_pkg;

    localparam int DATA_W  = 16;
    localparam int DUR_W   = 16;
    localparam int FRAME_W = 32;
    localparam int GAP_W   = 8;
    localparam int LIMIT_W = 5;
    localparam int STAT_W  = 2;

    localparam logic [GAP_W-1:0] GAP_RESET = 8'd15;
    localparam logic [DUR_W-1:0] DUR_MAX   = 16'hFFFF;

    // request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // response status codes
    localparam logic [STAT_W-1:0] ST_ACCEPT = 2'd0;
    localparam logic [STAT_W-1:0] ST_STALE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ITEM   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NONE   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    // per cell command
    typedef struct packed {
        logic shift;   // take the entry of the younger neighbor (or the new entry)
        logic rotate;  // take the entry of the older neighbor
        logic bump;    // saturating duration increment
    } t_cell_ctl;

endpackage

### rtl/core/tihr_req_if.sv
`timescale 1ns / 1ps
// request channel of the timestamped input history ring unit
// depends on tihr_pkg
interface tihr_req_if import tihr_pkg::*;;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [DATA_W-1:0]  input_data;
    logic [DUR_W-1:0]   input_duration;
    logic [FRAME_W-1:0] frame;
    logic [LIMIT_W-1:0] limit;

    modport source (output valid, req_type, input_data, input_duration, frame, limit,
                    input ready);
    modport sink   (input valid, req_type, input_data, input_duration, frame, limit,
                    output ready);
endinterface

### rtl/core/tihr_rsp_if.sv
`timescale 1ns / 1ps
// response channel of the timestamped input history ring unit
// depends on tihr_pkg
interface tihr_rsp_if import tihr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] entry_data;
    logic [DUR_W-1:0]  entry_duration;
    logic              last;

    modport source (output valid, status, entry_data, entry_duration, last,
                    input ready);
    modport sink   (input valid, status, entry_data, entry_duration, last,
                    output ready);
endinterface

### rtl/core/tihr_cell.sv
`timescale 1ns / 1ps
// one history cell: word, duration and start frame of one entry
// depends on tihr_pkg
module tihr_cell import tihr_pkg::*; #(
    parameter int WORD_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [WORD_W-1:0]  i_sh_word,
    input  logic [DUR_W-1:0]   i_sh_dur,
    input  logic [FRAME_W-1:0] i_sh_frame,
    input  logic [WORD_W-1:0]  i_rot_word,
    input  logic [DUR_W-1:0]   i_rot_dur,
    input  logic [FRAME_W-1:0] i_rot_frame,
    output logic [WORD_W-1:0]  o_word,
    output logic [DUR_W-1:0]   o_dur,
    output logic [FRAME_W-1:0] o_frame
);

    logic [WORD_W-1:0]  r_word;
    logic [DUR_W-1:0]   r_dur;
    logic [FRAME_W-1:0] r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_dur   <= '0;
            r_frame <= '0;
        end else if (i_ctl.shift) begin
            r_word  <= i_sh_word;
            r_dur   <= i_sh_dur;
            r_frame <= i_sh_frame;
        end else if (i_ctl.rotate) begin
            r_word  <= i_rot_word;
            r_dur   <= i_rot_dur;
            r_frame <= i_rot_frame;
        end else if (i_ctl.bump && (r_dur != DUR_MAX)) begin
            r_dur <= r_dur + 1'b1;
        end
    end

    assign o_word  = r_word;
    assign o_dur   = r_dur;
    assign o_frame = r_frame;

endmodule

### rtl/core/timestamped_input_history_ring_unit.sv
`timescale 1ns / 1ps
// top level of the timestamped input history ring unit
// depends on tihr_pkg, tihr_req_if, tihr_rsp_if, tihr_cell and the assert header
//
//  port        | dir | carries
//  ------------+-----+-----------------------------------------------
//  i_req       | in  | insert / query requests, valid-ready
//  o_rsp       | out | status and history entries, valid-ready, last
//  i_cfg_*     | in  | max_gap register write, no read-back
//
// an insert gives one response, registered in the cycle after it is taken
// a query rotates the cell chain once around in the walk state, then
// finishes in the done state with a final response
// a stalled response register freezes the walk; no new request while busy
// synchronous active-low reset clears the whole history directly, no sweep
`include "timestamped_input_history_ring_unit_assert.svh"

module timestamped_input_history_ring_unit import tihr_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int DATA_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tihr_req_if.sink         i_req,
    tihr_rsp_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic [GAP_W-1:0] i_cfg_wdata
);

    // stored word width: data beyond DATA_BITS is masked off on insert
    localparam int WordW = (DATA_BITS < DATA_W) ? DATA_BITS : DATA_W;
    localparam int StepW = $clog2(DEPTH);
    localparam int CntW0 = $clog2(DEPTH + 1);
    localparam int CntW  = (CntW0 > LIMIT_W) ? CntW0 : LIMIT_W;

    // cell chain: cell 0 always holds the newest entry while idle
    logic [WordW-1:0]   w_word  [DEPTH];
    logic [DUR_W-1:0]   w_dur   [DEPTH];
    logic [FRAME_W-1:0] w_frame [DEPTH];
    t_cell_ctl          w_ctl;

    logic [WordW-1:0]   w_new_word;
    logic [WordW-1:0]   w_head_word;
    logic [DUR_W-1:0]   w_head_dur;
    logic [FRAME_W-1:0] w_head_frame;

    assign w_new_word   = i_req.input_data[WordW-1:0];
    assign w_head_word  = w_word[0];
    assign w_head_dur   = w_dur[0];
    assign w_head_frame = w_frame[0];

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_ctl w_cctl;
        // only the newest cell ever takes a duration bump
        assign w_cctl.shift  = w_ctl.shift;
        assign w_cctl.rotate = w_ctl.rotate;
        assign w_cctl.bump   = (gi == 0) ? w_ctl.bump : 1'b0;

        if (gi == 0) begin : g_head
            tihr_cell #(.WORD_W(WordW)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_cctl),
                .i_sh_word   (w_new_word),
                .i_sh_dur    (i_req.input_duration),
                .i_sh_frame  (i_req.frame),
                .i_rot_word  (w_word[(gi + 1) % DEPTH]),
                .i_rot_dur   (w_dur[(gi + 1) % DEPTH]),
                .i_rot_frame (w_frame[(gi + 1) % DEPTH]),
                .o_word      (w_word[gi]),
                .o_dur       (w_dur[gi]),
                .o_frame     (w_frame[gi])
            );
        end else begin : g_body
            tihr_cell #(.WORD_W(WordW)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_cctl),
                .i_sh_word   (w_word[gi - 1]),
                .i_sh_dur    (w_dur[gi - 1]),
                .i_sh_frame  (w_frame[gi - 1]),
                .i_rot_word  (w_word[(gi + 1) % DEPTH]),
                .i_rot_dur   (w_dur[(gi + 1) % DEPTH]),
                .i_rot_frame (w_frame[(gi + 1) % DEPTH]),
                .o_word      (w_word[gi]),
                .o_dur       (w_dur[gi]),
                .o_frame     (w_frame[gi])
            );
        end
    end

    // configuration register
    logic [GAP_W-1:0] r_max_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gap <= GAP_RESET;
        end else if (i_cfg_we) begin
            r_max_gap <= i_cfg_wdata;
        end
    end

    // control state
    t_state           r_state, n_state;
    logic [StepW-1:0] r_step, n_step;
    logic [CntW-1:0]  r_n, n_n;
    logic             r_stop, n_stop;
    logic             r_pend_v, n_pend_v;
    logic             r_written, n_written;
    logic             r_out_valid, n_out_valid;

    // walk payload
    logic [CntW-1:0]    r_cap, n_cap;
    logic [FRAME_W-1:0] r_prev, n_prev;
    logic [WordW-1:0]   r_pend_word, n_pend_word;
    logic [DUR_W-1:0]   r_pend_dur, n_pend_dur;
    logic [WordW-1:0]   r_nw_word, n_nw_word;
    logic [DUR_W-1:0]   r_nw_dur, n_nw_dur;

    // response register
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_data, n_data;
    logic [DUR_W-1:0]  r_dur, n_dur;
    logic              r_last, n_last;

    logic             w_out_free;
    logic             w_req_ready;
    logic             w_req_fire;
    logic             w_gap_fail;
    logic             w_stop_now;
    logic [CntW-1:0]  w_limit;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    // requests are only taken while idle and the response register can take the answer
    assign w_req_ready = (r_state == S_IDLE) && w_out_free;
    assign w_req_fire  = i_req.valid && w_req_ready;
    assign w_limit     = CntW'(i_req.limit);

    // entry too old relative to the one visited before it
    assign w_gap_fail = ({1'b0, w_head_frame} + (FRAME_W + 1)'(r_max_gap) + 1'b1)
                        < {1'b0, r_prev};
    assign w_stop_now = r_stop || (r_n >= r_cap) || w_gap_fail;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_n         = r_n;
        n_stop      = r_stop;
        n_pend_v    = r_pend_v;
        n_written   = r_written;
        n_cap       = r_cap;
        n_prev      = r_prev;
        n_pend_word = r_pend_word;
        n_pend_dur  = r_pend_dur;
        n_nw_word   = r_nw_word;
        n_nw_dur    = r_nw_dur;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_data      = r_data;
        n_dur       = r_dur;
        n_last      = r_last;
        w_ctl       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_req_fire) begin
                    n_out_valid = 1'b1;
                    n_data      = '0;
                    n_dur       = '0;
                    n_last      = 1'b1;
                    if (i_req.req_type == REQ_INSERT) begin
                        if (w_head_frame >= i_req.frame) begin
                            n_status = ST_STALE;
                        end else begin
                            n_status = ST_ACCEPT;
                            if (w_head_word == w_new_word) begin
                                w_ctl.bump = 1'b1;
                            end else begin
                                w_ctl.shift = 1'b1;
                                n_written   = 1'b1;
                            end
                        end
                    end else if (!r_written || (w_head_frame >= i_req.frame)
                                 || (i_req.limit == '0)) begin
                        // empty history, stale query or zero limit
                        n_status = ST_NONE;
                    end else begin
                        n_out_valid = 1'b0;
                        n_state     = S_WALK;
                        n_step      = '0;
                        n_n         = '0;
                        n_stop      = 1'b0;
                        n_pend_v    = 1'b0;
                        n_prev      = i_req.frame;
                        n_cap       = (w_limit >= CntW'(DEPTH)) ? CntW'(DEPTH) : w_limit;
                        n_nw_word   = w_head_word;
                        n_nw_dur    = w_head_dur;
                    end
                end
            end
            S_WALK: begin
                if (w_out_free) begin
                    w_ctl.rotate = 1'b1;
                    if (w_stop_now) begin
                        n_stop = 1'b1;
                    end else begin
                        n_prev = w_head_frame;
                        if (w_head_word != '0) begin
                            // hold one item back so the final one can carry last
                            if (r_pend_v) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_ITEM;
                                n_data      = DATA_W'(r_pend_word);
                                n_dur       = r_pend_dur;
                                n_last      = 1'b0;
                            end
                            n_pend_v    = 1'b1;
                            n_pend_word = w_head_word;
                            n_pend_dur  = w_head_dur;
                            n_n         = r_n + 1'b1;
                        end
                    end
                    if (r_step == StepW'(DEPTH - 1)) begin
                        n_step  = '0;
                        n_state = S_DONE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                    if (r_pend_v) begin
                        n_status = ST_ITEM;
                        n_data   = DATA_W'(r_pend_word);
                        n_dur    = r_pend_dur;
                    end else if (r_nw_word != '0) begin
                        // nothing qualified: fall back to the newest entry
                        n_status = ST_ITEM;
                        n_data   = DATA_W'(r_nw_word);
                        n_dur    = r_nw_dur;
                    end else begin
                        n_status = ST_NONE;
                        n_data   = '0;
                        n_dur    = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_n         <= '0;
            r_stop      <= 1'b0;
            r_pend_v    <= 1'b0;
            r_written   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_n         <= n_n;
            r_stop      <= n_stop;
            r_pend_v    <= n_pend_v;
            r_written   <= n_written;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap       <= n_cap;
        r_prev      <= n_prev;
        r_pend_word <= n_pend_word;
        r_pend_dur  <= n_pend_dur;
        r_nw_word   <= n_nw_word;
        r_nw_dur    <= n_nw_dur;
        r_status    <= n_status;
        r_data      <= n_data;
        r_dur       <= n_dur;
        r_last      <= n_last;
    end

    assign i_req.ready          = w_req_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.entry_data     = r_data;
    assign o_rsp.entry_duration = r_dur;
    assign o_rsp.last           = r_last;

    // an insert always answers in the very next cycle, as a final response
    `TIHR_ASSERT_NEXT(a_insert_answers, i_clk, i_rst_n, w_req_fire && (i_req.req_type == REQ_INSERT), r_out_valid && r_last)
    // a response without last only comes out while a query is still running
    `TIHR_ASSERT_IMPLY(a_mid_item_busy, i_clk, i_rst_n, r_out_valid && !r_last, r_state != S_IDLE)
    // the walk never collects more items than the query allows
    `TIHR_ASSERT_IMPLY(a_count_capped, i_clk, i_rst_n, r_state == S_WALK, r_n <= r_cap)

endmodule
